// ----- design/nd_option_tlv_parser_macros.svh -----
// assertion macros for the neighbor discovery option parser
`ifndef ND_OPTION_TLV_PARSER_MACROS_SVH
`define ND_OPTION_TLV_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define NDOP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define NDOP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds through reset
`define NDOP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/nd_opt_pkg.sv -----
// shared types and constants for the neighbor discovery option parser
`timescale 1ns / 1ps

package nd_opt_pkg;

   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 48;
   localparam int CNT_W      = 11;
   localparam int UNIT_SHIFT = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int RSP_DATA_W = 104;

   // link address bytes follow the type and length bytes
   localparam logic [CNT_W-1:0] ADDR_FIRST = CNT_W'(2);
   localparam logic [CNT_W-1:0] ADDR_END   = CNT_W'(8);

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2,
      PH_SKIP = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CAP_NONE = 2'd0,
      CAP_SRC  = 2'd1,
      CAP_TGT  = 2'd2
   } cap_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_SHORT_HDR  = 2'd1,
      ST_ZERO_LEN   = 2'd2,
      ST_SHORT_BODY = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_CODE = 1'b0,
      CSR_TARGET_CODE = 1'b1
   } csr_type;

   localparam logic [BYTE_W-1:0] SOURCE_CODE_RESET = 8'd1;
   localparam logic [BYTE_W-1:0] TARGET_CODE_RESET = 8'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] option_byte;
      logic              byte_present;
      logic              last;
   } item_type;

   // packed so that status sits in the lowest bits
   typedef struct packed {
      logic              repeat_seen;
      logic [ADDR_W-1:0] target_link_addr;
      logic              target_found;
      logic [ADDR_W-1:0] source_link_addr;
      logic              source_found;
      status_type        status;
   } result_type;

endpackage

// ----- design/nd_opt_in_stage.sv -----
// input register stage for the option byte stream
`timescale 1ns / 1ps

module nd_opt_in_stage
   import nd_opt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  logic     advance,
   output logic     held_valid,
   output item_type held_item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // refill in the same cycle the held item moves on
   assign in_ready   = !valid_ff || advance;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !advance);
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ----- design/nd_opt_parser.sv -----
// option walk state and per-byte update, result formed on the last item
`timescale 1ns / 1ps

module nd_opt_parser
   import nd_opt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  item_type          item,
   input  logic [BYTE_W-1:0] source_code,
   input  logic [BYTE_W-1:0] target_code,
   output result_type        result
);

   phase_type         phase_ff, phase_in, phase_upd;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_upd, cnt_inc;
   logic [CNT_W-1:0]  size_ff, size_in, size_upd;
   cap_type           cap_ff, cap_in, cap_upd;
   logic [ADDR_W-1:0] src_ff, src_in, src_upd;
   logic [ADDR_W-1:0] tgt_ff, tgt_in, tgt_upd;
   logic [1:0]        found_ff, found_in, found_upd;
   status_type        err_ff, err_in, err_upd;
   logic              rep_ff, rep_in, rep_upd;
   status_type        status;
   logic [BYTE_W-1:0] b;

   assign b       = item.option_byte;
   assign cnt_inc = cnt_ff + CNT_W'(1);

   always_comb begin
      phase_upd = phase_ff;
      cnt_upd   = cnt_ff;
      size_upd  = size_ff;
      cap_upd   = cap_ff;
      src_upd   = src_ff;
      tgt_upd   = tgt_ff;
      found_upd = found_ff;
      err_upd   = err_ff;
      rep_upd   = rep_ff;

      if (step && item.byte_present) begin
         case (phase_ff)
            PH_TYPE: begin
               cap_upd = CAP_NONE;
               // equal codes resolve to the source option
               if (b == source_code) begin
                  if (found_ff[0]) begin
                     rep_upd = 1'b1;
                  end else begin
                     found_upd[0] = 1'b1;
                     cap_upd      = CAP_SRC;
                  end
               end else if (b == target_code) begin
                  if (found_ff[1]) begin
                     rep_upd = 1'b1;
                  end else begin
                     found_upd[1] = 1'b1;
                     cap_upd      = CAP_TGT;
                  end
               end
               cnt_upd   = CNT_W'(1);
               phase_upd = PH_LEN;
            end
            PH_LEN: begin
               if (b == '0) begin
                  err_upd   = ST_ZERO_LEN;
                  phase_upd = PH_SKIP;
               end else begin
                  size_upd  = CNT_W'(b) << UNIT_SHIFT;
                  cnt_upd   = ADDR_FIRST;
                  phase_upd = PH_BODY;
               end
            end
            PH_BODY: begin
               if (cnt_ff >= ADDR_FIRST && cnt_ff < ADDR_END) begin
                  if (cap_ff == CAP_SRC) begin
                     src_upd = {src_ff[ADDR_W-BYTE_W-1:0], b};
                  end else if (cap_ff == CAP_TGT) begin
                     tgt_upd = {tgt_ff[ADDR_W-BYTE_W-1:0], b};
                  end
               end
               if (cnt_inc >= size_ff) begin
                  phase_upd = PH_TYPE;
                  cnt_upd   = '0;
                  cap_upd   = CAP_NONE;
               end else begin
                  cnt_upd = cnt_inc;
               end
            end
            PH_SKIP: begin
            end
            default: begin
            end
         endcase
      end

      if (err_upd != ST_OK) begin
         status = err_upd;
      end else if (phase_upd == PH_LEN) begin
         status = ST_SHORT_HDR;
      end else if (phase_upd == PH_BODY) begin
         status = ST_SHORT_BODY;
      end else begin
         status = ST_OK;
      end

      result = '0;
      result.status = status;
      if (status == ST_OK) begin
         result.source_found     = found_upd[0];
         result.source_link_addr = found_upd[0] ? src_upd : '0;
         result.target_found     = found_upd[1];
         result.target_link_addr = found_upd[1] ? tgt_upd : '0;
         result.repeat_seen      = rep_upd;
      end

      // the area ends here: start the next one clean
      if (step && item.last) begin
         phase_in = PH_TYPE;
         cnt_in   = '0;
         size_in  = '0;
         cap_in   = CAP_NONE;
         src_in   = '0;
         tgt_in   = '0;
         found_in = '0;
         err_in   = ST_OK;
         rep_in   = 1'b0;
      end else begin
         phase_in = phase_upd;
         cnt_in   = cnt_upd;
         size_in  = size_upd;
         cap_in   = cap_upd;
         src_in   = src_upd;
         tgt_in   = tgt_upd;
         found_in = found_upd;
         err_in   = err_upd;
         rep_in   = rep_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         cnt_ff   <= '0;
         size_ff  <= '0;
         cap_ff   <= CAP_NONE;
         src_ff   <= '0;
         tgt_ff   <= '0;
         found_ff <= '0;
         err_ff   <= ST_OK;
         rep_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         size_ff  <= size_in;
         cap_ff   <= cap_in;
         src_ff   <= src_in;
         tgt_ff   <= tgt_in;
         found_ff <= found_in;
         err_ff   <= err_in;
         rep_ff   <= rep_in;
      end
   end

endmodule

// ----- design/nd_option_tlv_parser.sv -----
// top level of the neighbor discovery option parser
`timescale 1ns / 1ps

// Walks the option area of an IPv6 neighbor discovery message, one byte per
// transfer, and on the transfer marked tlast returns one result with the
// status and the link addresses of the first source and target options.
// Every transfer without tlast gives no result; a transfer with tuser low and
// tlast low is dropped. The block takes one transfer every clock cycle while
// no tlast transfer waits for the result register; each byte needs one step
// of the option walk, done between the input and the result register. While
// a result waits on rsp_tready, bytes flow on up to the next tlast transfer,
// which waits in the input register. The user writes the option type codes
// through the csr port while idle; the block itself does not enforce this.
module nd_option_tlv_parser
   import nd_opt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // option_byte
   input  logic                  req_tuser,   // byte_present
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], source_found, source_link_addr[47:0], target_found,
   // target_link_addr[47:0], repeat_seen, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0]     csr_wdata
);

   logic [BYTE_W-1:0]     src_code_ff;
   logic [BYTE_W-1:0]     tgt_code_ff;
   item_type              req_item;
   item_type              held_item;
   logic                  held_valid;
   logic                  out_free;
   logic                  advance;
   logic                  load_rsp;
   result_type            result;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign req_item.option_byte  = req_tdata;
   assign req_item.byte_present = req_tuser;
   assign req_item.last         = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_code_ff <= SOURCE_CODE_RESET;
         tgt_code_ff <= TARGET_CODE_RESET;
      end else if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_SOURCE_CODE: src_code_ff <= csr_wdata;
            CSR_TARGET_CODE: tgt_code_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // only a last item needs room in the result register
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance  = held_valid && (!held_item.last || out_free);
   assign load_rsp = advance && held_item.last;

   nd_opt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   nd_opt_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (held_item),
      .source_code (src_code_ff),
      .target_code (tgt_code_ff),
      .result      (result)
   );

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= RSP_DATA_W'(result);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- design/nd_opt_checker.sv -----
// port-level checks for the option parser, bound to the top level
`timescale 1ns / 1ps
`include "nd_option_tlv_parser_macros.svh"

module nd_opt_checker
   import nd_opt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result stays put
   `NDOP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // an error result carries no flags and no addresses
   `NDOP_ASSERT_IMP(a_err_clean, clock, reset, rsp_tvalid && (rsp_tdata[1:0] != 2'd0), rsp_tdata[RSP_DATA_W-1:2] == '0, "error result carries data")

   // an address without its found flag reads zero
   `NDOP_ASSERT_IMP(a_addr_gated, clock, reset, rsp_tvalid && (!rsp_tdata[2] || !rsp_tdata[51]), (rsp_tdata[2] || rsp_tdata[50:3] == '0) && (rsp_tdata[51] || rsp_tdata[99:52] == '0), "address without found flag")

   // no result in the cycle after a reset edge
   `NDOP_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind nd_option_tlv_parser nd_opt_checker u_nd_opt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/sv/nd_opt_tb_pkg.sv -----
// option walk predictor and result checker for the option parser testbench
`timescale 1ns / 1ps

package nd_opt_tb_pkg;
   import nd_opt_pkg::*;

   localparam int RES_W = $bits(result_type);

   class nd_scoreboard;
      logic [BYTE_W-1:0] source_code;
      logic [BYTE_W-1:0] target_code;
      phase_type         phase;
      logic [CNT_W-1:0]  pos;
      logic [CNT_W-1:0]  size;
      cap_type           cap;
      logic [ADDR_W-1:0] source_addr;
      logic [ADDR_W-1:0] target_addr;
      logic              source_seen;
      logic              target_seen;
      status_type        err;
      logic              repeat_hit;
      result_type        parse_results_q[$];
      int                errors;

      function new();
         source_code = SOURCE_CODE_RESET;
         target_code = TARGET_CODE_RESET;
         errors      = 0;
         clear_area();
      endfunction

      function void clear_area();
         phase       = PH_TYPE;
         pos         = '0;
         size        = '0;
         cap         = CAP_NONE;
         source_addr = '0;
         target_addr = '0;
         source_seen = 1'b0;
         target_seen = 1'b0;
         err         = ST_OK;
         repeat_hit  = 1'b0;
      endfunction

      function void set_codes(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] t);
         source_code = s;
         target_code = t;
      endfunction

      function int pending();
         return parse_results_q.size();
      endfunction

      // one accepted transfer; a transfer with tlast queues the area result
      function void take_option_item(logic [BYTE_W-1:0] b, logic present, logic last);
         result_type r;
         if (present) begin
            case (phase)
               PH_TYPE: begin
                  cap = CAP_NONE;
                  // source wins when both codes are equal
                  if (b == source_code) begin
                     if (source_seen) begin
                        repeat_hit = 1'b1;
                     end else begin
                        source_seen = 1'b1;
                        cap = CAP_SRC;
                     end
                  end else if (b == target_code) begin
                     if (target_seen) begin
                        repeat_hit = 1'b1;
                     end else begin
                        target_seen = 1'b1;
                        cap = CAP_TGT;
                     end
                  end
                  pos   = CNT_W'(1);
                  phase = PH_LEN;
               end
               PH_LEN: begin
                  if (b == '0) begin
                     err   = ST_ZERO_LEN;
                     phase = PH_SKIP;
                  end else begin
                     size  = CNT_W'(b) << UNIT_SHIFT;
                     pos   = ADDR_FIRST;
                     phase = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (pos >= ADDR_FIRST && pos < ADDR_END) begin
                     if (cap == CAP_SRC) begin
                        source_addr = {source_addr[ADDR_W-BYTE_W-1:0], b};
                     end else if (cap == CAP_TGT) begin
                        target_addr = {target_addr[ADDR_W-BYTE_W-1:0], b};
                     end
                  end
                  pos = pos + CNT_W'(1);
                  if (pos >= size) begin
                     phase = PH_TYPE;
                     pos   = '0;
                     cap   = CAP_NONE;
                  end
               end
               default: ;
            endcase
         end
         if (!last) return;
         r = '0;
         if (err != ST_OK) begin
            r.status = err;
         end else if (phase == PH_LEN) begin
            r.status = ST_SHORT_HDR;
         end else if (phase == PH_BODY) begin
            r.status = ST_SHORT_BODY;
         end else begin
            r.status           = ST_OK;
            r.source_found     = source_seen;
            r.source_link_addr = source_seen ? source_addr : '0;
            r.target_found     = target_seen;
            r.target_link_addr = target_seen ? target_addr : '0;
            r.repeat_seen      = repeat_hit;
         end
         parse_results_q.push_back(r);
         clear_area();
      endfunction

      function void compare(string what, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
         end
      endfunction

      function void check_parse_result(logic [RSP_DATA_W-1:0] data);
         result_type want;
         result_type got;
         if (parse_results_q.size() == 0) begin
            errors++;
            $display("%0t: result transfer, expected none actual %0h", $time, data);
            return;
         end
         want = parse_results_q.pop_front();
         got  = result_type'(data[RES_W-1:0]);
         compare("status", 64'(want.status), 64'(got.status));
         compare("source_found", 64'(want.source_found), 64'(got.source_found));
         compare("source_link_addr", 64'(want.source_link_addr), 64'(got.source_link_addr));
         compare("target_found", 64'(want.target_found), 64'(got.target_found));
         compare("target_link_addr", 64'(want.target_link_addr), 64'(got.target_link_addr));
         compare("repeat_seen", 64'(want.repeat_seen), 64'(got.repeat_seen));
         compare("zero fill", 64'(0), 64'(data[RSP_DATA_W-1:RES_W]));
      endfunction
   endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// top level testbench for the neighbor discovery option parser
`timescale 1ns / 1ps

module tb_top;
   import nd_opt_pkg::*;
   import nd_opt_tb_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [BYTE_W-1:0]     csr_wdata = '0;

   nd_scoreboard      sb;
   bit                idle_on = 1'b0;
   bit                idle_area = 1'b0;
   int                rsp_stall = 0;
   logic [BYTE_W-1:0] src_code = SOURCE_CODE_RESET;
   logic [BYTE_W-1:0] tgt_code = TARGET_CODE_RESET;
   logic [BYTE_W-1:0] area_bytes[$];
   bit                end_marker;

   nd_option_tlv_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.take_option_item(req_tdata, req_tuser, req_tlast);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_parse_result(rsp_tdata);
      end
   end

   // receiver stalls come in bursts of random length while idle_on is set
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic present,
                            input logic last);
      if (idle_area && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= present;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // a trailing empty transfer closes the area when end_marker is set or the area is empty
   task automatic drive_area();
      idle_area = idle_on && $urandom_range(0, 3) != 0;
      for (int i = 0; i < area_bytes.size(); i++) begin
         if ($urandom_range(0, 14) == 0) send_item(BYTE_W'($urandom), 1'b0, 1'b0);
         send_item(area_bytes[i], 1'b1, !end_marker && i == area_bytes.size() - 1);
      end
      if (end_marker || area_bytes.size() == 0) begin
         send_item(BYTE_W'($urandom), 1'b0, 1'b1);
      end
   endtask

   task automatic gen_area();
      int kind;
      int len;
      int keep;
      logic [BYTE_W-1:0] t;
      area_bytes.delete();
      kind = $urandom_range(0, 9);
      end_marker = $urandom_range(0, 2) == 0;
      if (kind == 9) begin
         repeat ($urandom_range(1, 12)) area_bytes.push_back(BYTE_W'($urandom));
         return;
      end
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 3))
            0, 1: t = src_code;
            2: t = tgt_code;
            default: t = BYTE_W'($urandom);
         endcase
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
         area_bytes.push_back(t);
         area_bytes.push_back(BYTE_W'(len));
         repeat (len * 8 - 2) area_bytes.push_back(BYTE_W'($urandom));
      end
      if (kind == 7 && area_bytes.size() > 1) begin
         // cut the area short somewhere inside
         keep = $urandom_range(1, area_bytes.size() - 1);
         while (area_bytes.size() > keep) void'(area_bytes.pop_back());
      end else if (kind == 8) begin
         area_bytes.push_back(BYTE_W'($urandom));
         area_bytes.push_back(8'h00);
         repeat ($urandom_range(0, 5)) area_bytes.push_back(BYTE_W'($urandom));
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(input int target);
      int sent;
      sent = 0;
      while (sent < target) begin
         gen_area();
         sent += area_bytes.size();
         drive_area();
      end
      settle();
   endtask

   task automatic write_codes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] t);
      csr_we    <= 1'b1;
      csr_index <= CSR_SOURCE_CODE;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_TARGET_CODE;
      csr_wdata <= t;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_codes(s, t);
      src_code = s;
      tgt_code = t;
   endtask

   initial begin
      logic [BYTE_W-1:0] s;
      logic [BYTE_W-1:0] t;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      // empty area
      area_bytes.delete();
      end_marker = 1'b0;
      drive_area();
      // source and target options, a dropped transfer, closed by an empty transfer
      send_item(8'hC3, 1'b0, 1'b0);
      area_bytes = '{8'h01, 8'h01, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE,
                     8'h02, 8'h01, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h0F, 8'hF0};
      end_marker = 1'b1;
      drive_area();
      // zero length option with a byte after it
      area_bytes = '{8'h03, 8'h00, 8'h77};
      end_marker = 1'b0;
      drive_area();
      // area ends after the type byte
      area_bytes = '{8'h01};
      drive_area();
      // area ends inside a maximum length body
      area_bytes = '{8'hFF, 8'hFF, 8'h12};
      drive_area();
      // one full long option, then a source option
      area_bytes = '{8'h80, 8'h10};
      repeat (126) area_bytes.push_back(BYTE_W'($urandom));
      area_bytes.push_back(8'h01);
      area_bytes.push_back(8'h01);
      repeat (6) area_bytes.push_back(BYTE_W'($urandom));
      drive_area();

      run_random(80);
      s = BYTE_W'($urandom);
      do t = BYTE_W'($urandom); while (t == s);
      write_codes(s, t);
      run_random(80);
      write_codes(8'h00, 8'hFF);
      run_random(80);
      // equal codes: matches count as source options
      s = BYTE_W'($urandom);
      write_codes(s, s);
      run_random(80);
      idle_on = 1'b0;
      write_codes(8'hFF, 8'h00);
      run_random(80);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- nd_option_tlv_parser.f -----
+incdir+design
design/nd_opt_pkg.sv
design/nd_opt_in_stage.sv
design/nd_opt_parser.sv
design/nd_option_tlv_parser.sv
design/nd_opt_checker.sv
tb/sv/nd_opt_tb_pkg.sv
tb/sv/tb_top.sv
